// ===== sv/gclfu_pkg.sv =====
// Shared types and constants for the LFU cache directory.
// Used by gclfu_ctrl, gclfu_dp and the top level group_cache_lfu_replacement.
package gclfu_pkg;

  localparam int ENTRIES_DEF = 8;
  localparam int DEV_W       = 16;
  localparam int GRP_W       = 8;
  localparam int CNT_W       = 16;
  localparam int MODE_W      = 2;
  localparam int SLOT_W      = 3;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  localparam logic             OP_ACCESS  = 1'b0;
  localparam logic             OP_AGE     = 1'b1;
  localparam logic [MODE_W-1:0] MODE_DIRTY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAN = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH,
    ST_COMMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;   // capture the request, clear scan results
    logic issue;   // read the entry at the scan index, advance
    logic commit;  // update the directory and load the result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;  // scan index is at the last entry
    logic out_free;   // result register can take a new result
  } status_t;

  // One directory entry as held in the entry memory.
  typedef struct packed {
    logic [DEV_W-1:0] dev;
    logic [GRP_W-1:0] grp;
    logic [CNT_W-1:0] count;
    logic             dirty;
  } entry_t;

endpackage

// ===== sv/gclfu_ctrl.sv =====
// Controller state machine for the LFU cache directory.
// Depends on gclfu_pkg (state_t, cmd_t, status_t).
module gclfu_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  gclfu_pkg::status_t status,
  output gclfu_pkg::cmd_t    cmd
);
  import gclfu_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      // hold off requests while reset is applied
      ST_IDLE: begin
        in_stall = rst;
        if (in_valid && !rst) begin
          cmd.start  = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.issue = 1'b1;
        if (status.scan_last) begin
          state_next = ST_FLUSH;
        end
      end
      // last read data is evaluated here
      ST_FLUSH: begin
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/gclfu_dp.sv =====
// Datapath of the LFU cache directory: entry memory, valid bits, scan
// registers and result register. Depends on gclfu_pkg.
module gclfu_dp #(
  parameter int ENTRIES = gclfu_pkg::ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  gclfu_pkg::cmd_t                cmd,
  output gclfu_pkg::status_t             status,
  input  logic                           op,
  input  logic [gclfu_pkg::DEV_W-1:0]    dev_addr,
  input  logic [gclfu_pkg::GRP_W-1:0]    group_id,
  input  logic [gclfu_pkg::MODE_W-1:0]   write_mode,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           hit,
  output logic [gclfu_pkg::SLOT_W-1:0]   slot,
  output logic                           needs_load,
  output logic                           evicted,
  output logic [gclfu_pkg::DEV_W-1:0]    evicted_dev_addr,
  output logic [gclfu_pkg::GRP_W-1:0]    evicted_group,
  output logic                           writeback_needed
);
  import gclfu_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  entry_t           mem [ENTRIES];
  entry_t           rd_data;
  logic [IDX_W-1:0] rd_idx;
  logic             rd_live;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;

  logic [ENTRIES-1:0] valid;

  // captured request
  logic              op_q;
  logic [DEV_W-1:0]  dev_q;
  logic [GRP_W-1:0]  grp_q;
  logic [MODE_W-1:0] mode_q;

  logic [IDX_W-1:0] scan_idx;

  // scan results
  logic             hit_f;
  logic [IDX_W-1:0] hit_idx;
  logic [CNT_W-1:0] hit_cnt;
  logic             hit_dirty;
  logic             free_f;
  logic [IDX_W-1:0] free_idx;
  logic [IDX_W-1:0] vic_idx;
  logic [CNT_W-1:0] vic_cnt;
  logic [DEV_W-1:0] vic_dev;
  logic [GRP_W-1:0] vic_grp;
  logic             vic_dirty;

  logic             e_valid;
  logic             e_match;
  logic             new_dirty;
  logic [IDX_W-1:0] miss_idx;
  logic [IDX_W-1:0] res_idx;
  logic [IDX_W+SLOT_W-1:0] res_idx_ext;

  assign status.scan_last = (scan_idx == LAST_IDX);
  assign status.out_free  = !out_valid || !out_stall;

  assign e_valid  = valid[rd_idx];
  assign e_match  = e_valid && (rd_data.dev == dev_q) && (rd_data.grp == grp_q);
  assign miss_idx = free_f ? free_idx : vic_idx;
  assign res_idx  = hit_f ? hit_idx : miss_idx;
  assign res_idx_ext = {{SLOT_W{1'b0}}, res_idx};

  always_comb begin
    priority if (mode_q == MODE_DIRTY) begin
      new_dirty = 1'b1;
    end else if (mode_q == MODE_CLEAN) begin
      new_dirty = 1'b0;
    end else begin
      new_dirty = hit_dirty;
    end
  end

  // single write port: aging write-back during scan, update at commit
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_idx;
    wr_data = rd_data;
    if (rd_live && op_q == OP_AGE) begin
      wr_en         = 1'b1;
      wr_data.count = rd_data.count >> 1;
    end else if (cmd.commit && op_q == OP_ACCESS) begin
      wr_en       = 1'b1;
      wr_data.dev = dev_q;
      wr_data.grp = grp_q;
      if (hit_f) begin
        wr_addr       = hit_idx;
        wr_data.count = (hit_cnt == COUNT_MAX) ? hit_cnt : hit_cnt + CNT_W'(1);
        wr_data.dirty = new_dirty;
      end else begin
        wr_addr       = miss_idx;
        wr_data.count = '0;
        wr_data.dirty = (mode_q == MODE_DIRTY);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[scan_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_live  <= 1'b0;
      scan_idx <= '0;
    end else begin
      rd_live <= cmd.issue;
      if (cmd.start) begin
        scan_idx <= '0;
      end else if (cmd.issue && !status.scan_last) begin
        scan_idx <= scan_idx + IDX_W'(1);
      end
      if (cmd.commit && op_q == OP_ACCESS && !hit_f) begin
        valid[miss_idx] <= 1'b1;
      end
    end
    rd_idx <= scan_idx;
  end

  // request capture and scan evaluation
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_q   <= op;
      dev_q  <= dev_addr;
      grp_q  <= group_id;
      mode_q <= write_mode;
      hit_f  <= 1'b0;
      free_f <= 1'b0;
    end else if (rd_live && op_q == OP_ACCESS) begin
      if (e_match && !hit_f) begin
        hit_f     <= 1'b1;
        hit_idx   <= rd_idx;
        hit_cnt   <= rd_data.count;
        hit_dirty <= rd_data.dirty;
      end
      if (!e_valid && !free_f) begin
        free_f   <= 1'b1;
        free_idx <= rd_idx;
      end
      // strict less keeps the lowest index on ties
      if (rd_idx == '0 || rd_data.count < vic_cnt) begin
        vic_idx   <= rd_idx;
        vic_cnt   <= rd_data.count;
        vic_dev   <= rd_data.dev;
        vic_grp   <= rd_data.grp;
        vic_dirty <= rd_data.dirty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (op_q == OP_AGE) begin
        hit              <= 1'b0;
        slot             <= '0;
        needs_load       <= 1'b0;
        evicted          <= 1'b0;
        evicted_dev_addr <= '0;
        evicted_group    <= '0;
        writeback_needed <= 1'b0;
      end else begin
        hit        <= hit_f;
        slot       <= res_idx_ext[SLOT_W-1:0];
        needs_load <= !hit_f;
        if (!hit_f && !free_f) begin
          evicted          <= 1'b1;
          evicted_dev_addr <= vic_dev;
          evicted_group    <= vic_grp;
          writeback_needed <= vic_dirty;
        end else begin
          evicted          <= 1'b0;
          evicted_dev_addr <= '0;
          evicted_group    <= '0;
          writeback_needed <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== sv/group_cache_lfu_replacement.sv =====
// Fully associative cache directory with least-frequently-used replacement
// and aging. The directory lives in a memory with one read port, and every
// request, access or aging tick, reads every entry once in index order; an
// access finds the matching tag, the first free entry and the lowest-count
// victim there, then writes back at commit. An aging tick halves the counts
// in the same sweep. One request is in work at a time; a finished result
// waits in the output register while the next request is taken. The slot
// output carries the low three bits of the entry index.
module group_cache_lfu_replacement #(
  parameter int ENTRIES = gclfu_pkg::ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           op,
  input  logic [gclfu_pkg::DEV_W-1:0]    dev_addr,
  input  logic [gclfu_pkg::GRP_W-1:0]    group_id,
  input  logic [gclfu_pkg::MODE_W-1:0]   write_mode,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           hit,
  output logic [gclfu_pkg::SLOT_W-1:0]   slot,
  output logic                           needs_load,
  output logic                           evicted,
  output logic [gclfu_pkg::DEV_W-1:0]    evicted_dev_addr,
  output logic [gclfu_pkg::GRP_W-1:0]    evicted_group,
  output logic                           writeback_needed
);
  import gclfu_pkg::*;

  cmd_t    cmd;
  status_t status;

  gclfu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  gclfu_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .op               (op),
    .dev_addr         (dev_addr),
    .group_id         (group_id),
    .write_mode       (write_mode),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .hit              (hit),
    .slot             (slot),
    .needs_load       (needs_load),
    .evicted          (evicted),
    .evicted_dev_addr (evicted_dev_addr),
    .evicted_group    (evicted_group),
    .writeback_needed (writeback_needed)
  );

endmodule
